@@ src/sapq_pkg.sv @@
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and constants for the sorted array priority queue: store
// geometry, command and status codes, payload structs, and the control and
// status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package sapq_pkg;

  // Store geometry
  localparam int DEPTH = 32;
  localparam int AW    = $clog2(DEPTH);      // slot index width
  localparam int CW    = $clog2(DEPTH + 1);  // entry count width

  // Command codes
  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_SIZE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // Request payload
  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } sapq_req_t;

  // Result payload
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [5:0]         count;
  } sapq_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_item;   // capture request
    logic       pos_load_cnt; // scan position starts at tail
    logic       pos_load_one; // position one, reads the head slot
    logic       pos_dec;     // step scan toward the head
    logic       wr_val;      // write request value at scan position
    logic       wr_rdata;    // move read entry up one slot
    logic       head_inc;    // drop the head entry
    logic       cnt_inc;
    logic       cnt_dec;
    logic       respond;     // issue a result
    logic [1:0] rsp_status;
    logic       rsp_data;    // result data is the read entry, else zero
  } sapq_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] command;
    logic       empty;
    logic       full;
    logic       greater;  // read entry is greater than request value
    logic       pos_one;  // scan position is one
  } sapq_stat_t;

endpackage

@@ src/sapq_datapath.sv @@
// ----------------------------------------------------------------------------
// sapq_datapath
// Circular sorted store with one write and one registered read port, head
// pointer, entry count, scan position, compare and result register.
// ----------------------------------------------------------------------------
module sapq_datapath
  import sapq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sapq_req_t  item,
  input  sapq_ctrl_t ctrl,
  output sapq_stat_t stat,
  output logic       done,
  output sapq_rsp_t  result
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  sapq_req_t          req;
  logic [AW-1:0]      head;
  logic [AW-1:0]      pos;
  logic [AW-1:0]      pos_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               we;
  logic signed [31:0] wdata;

  // Logical slot to physical slot, head relative
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h,
                                         input logic [AW-1:0] l);
    logic [AW:0] sum;
    sum = {1'b0, h} + {1'b0, l};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Scan position update
  always_comb begin
    priority if (ctrl.pos_load_cnt) begin
      pos_next = count[AW-1:0];
    end else if (ctrl.pos_load_one) begin
      pos_next = AW'(1);
    end else if (ctrl.pos_dec) begin
      pos_next = pos - AW'(1);
    end else begin
      pos_next = pos;
    end
  end

  // Count update
  always_comb begin
    priority if (ctrl.cnt_inc) begin
      count_next = count + CW'(1);
    end else if (ctrl.cnt_dec) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  // Memory port addressing: always prefetch the slot below the next position
  assign raddr = phys(head, pos_next - AW'(1));
  assign waddr = phys(head, pos);
  assign we    = ctrl.wr_val | ctrl.wr_rdata;
  assign wdata = ctrl.wr_rdata ? rdata : req.value;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Request and scan registers
  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      req <= item;
    end
    pos <= pos_next;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= ctrl.respond;
      if (ctrl.head_inc) begin
        head <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctrl.respond) begin
      result.status <= ctrl.rsp_status;
      result.data   <= ctrl.rsp_data ? rdata : 32'sd0;
      result.count  <= 6'(count_next);
    end
  end

  // Status to controller
  assign stat.command = req.command;
  assign stat.empty   = (count == '0);
  assign stat.full    = (count == CW'(DEPTH));
  assign stat.greater = (rdata > req.value);
  assign stat.pos_one = (pos == AW'(1));

endmodule

@@ src/sapq_ctrl.sv @@
// ----------------------------------------------------------------------------
// sapq_ctrl
// Command sequencer: decodes each request, runs the insertion scan one slot
// per cycle, and issues the single result of every request.
// ----------------------------------------------------------------------------
module sapq_ctrl
  import sapq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  sapq_stat_t stat,
  output logic       busy,
  output sapq_ctrl_t ctrl
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_ENQ_SCAN = 3'd2;
  localparam logic [2:0] S_ENQ_PUT  = 3'd3;
  localparam logic [2:0] S_DEQ_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    ctrl       = '0;
    ctrl.rsp_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load_item = 1'b1;
          state_next     = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.command)
          CMD_ENQ: begin
            if (stat.full) begin
              ctrl.respond    = 1'b1;
              ctrl.rsp_status = ST_OVERFLOW;
              state_next      = S_IDLE;
            end else begin
              ctrl.pos_load_cnt = 1'b1;
              state_next        = stat.empty ? S_ENQ_PUT : S_ENQ_SCAN;
            end
          end
          CMD_DEQ: begin
            if (stat.empty) begin
              ctrl.respond    = 1'b1;
              ctrl.rsp_status = ST_UNDERFLOW;
              state_next      = S_IDLE;
            end else begin
              ctrl.pos_load_one = 1'b1;
              state_next        = S_DEQ_OUT;
            end
          end
          CMD_SIZE: begin
            ctrl.respond    = 1'b1;
            ctrl.rsp_status = stat.empty ? ST_UNDERFLOW : ST_OK;
            state_next      = S_IDLE;
          end
          default: begin
            // unused code: no change, plain result
            ctrl.respond = 1'b1;
            state_next   = S_IDLE;
          end
        endcase
      end
      S_ENQ_SCAN: begin
        if (stat.greater) begin
          // move larger entry up, keep scanning toward the head
          ctrl.wr_rdata = 1'b1;
          ctrl.pos_dec  = 1'b1;
          if (stat.pos_one) begin
            state_next = S_ENQ_PUT;
          end
        end else begin
          ctrl.wr_val  = 1'b1;
          ctrl.cnt_inc = 1'b1;
          ctrl.respond = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_ENQ_PUT: begin
        ctrl.wr_val  = 1'b1;
        ctrl.cnt_inc = 1'b1;
        ctrl.respond = 1'b1;
        state_next   = S_IDLE;
      end
      S_DEQ_OUT: begin
        ctrl.head_inc = 1'b1;
        ctrl.cnt_dec  = 1'b1;
        ctrl.respond  = 1'b1;
        ctrl.rsp_data = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/sorted_array_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Ascending priority queue of signed 32-bit values in a sorted circular store.
// ----------------------------------------------------------------------------
// Usage:
//   A request (item: command, value) transfers at a rising edge with start
//   high and busy low. Commands: enqueue, dequeue smallest, query size.
//   Each request gives exactly one result on result, valid for the single
//   cycle that done is high; the receiver cannot stall it.
//   Each request passes through an execute state; size query, overflow,
//   underflow and unused code respond from there. Dequeue responds once the
//   head slot is read out of the store's read port. Enqueue scans past the
//   m stored entries greater than the value; the insertion scan moves one
//   entry per cycle through the single memory write port.
//   busy stays high until the result cycle; a new request can transfer at
//   the edge that ends the result cycle. One request is in flight at a time.
//   Reset clears the count and head pointer; the queue is empty and ready
//   in the first cycle after reset. No clearing pass runs over the store.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue
  import sapq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  sapq_req_t item,
  output logic      busy,
  output logic      done,
  output sapq_rsp_t result
);

  sapq_ctrl_t ctrl;
  sapq_stat_t stat;

  // Sequencer
  sapq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // Store and result datapath
  sapq_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctrl   (ctrl),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

@@ sim/tb_sorted_array_priority_queue.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_array_priority_queue
// Self-checking bench for the sorted array priority queue. A directed opening
// covers empty-queue errors, the unused command code, extreme and repeated
// values. It is followed by random command streams that swing the queue
// between full and empty. A local sorted-list predictor supplies the
// expected status, data and count of every transfer.
// ----------------------------------------------------------------------------
module tb_sorted_array_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import sapq_pkg::*;

  // Command code with no defined operation
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES = DEPTH + 8;

  typedef enum int {FILL_BIAS, DRAIN_BIAS, MIXED} stream_mode_t;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  sapq_req_t item  = '0;
  logic      busy;
  logic      done;
  sapq_rsp_t result;

  sapq_req_t          pending_reqs[$];
  sapq_rsp_t          expected_rsps[$];
  logic signed [31:0] sorted_vals[$];

  int send_idle_pct = 0;
  int gen_count     = 0;
  bit failed        = 1'b0;

  sorted_array_priority_queue uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predict one result and update the local sorted list
  function automatic sapq_rsp_t predict_response(sapq_req_t req);
    sapq_rsp_t rsp;
    int slot;
    rsp = '0;
    case (req.command)
      CMD_ENQ: begin
        if (sorted_vals.size() >= DEPTH) begin
          rsp.status = ST_OVERFLOW;
        end else begin
          // insert after every equal value so ties leave in arrival order
          slot = sorted_vals.size();
          while (slot > 0 && sorted_vals[slot-1] > req.value) slot--;
          sorted_vals.insert(slot, req.value);
        end
      end
      CMD_DEQ: begin
        if (sorted_vals.size() == 0) rsp.status = ST_UNDERFLOW;
        else rsp.data = sorted_vals.pop_front();
      end
      CMD_SIZE: begin
        if (sorted_vals.size() == 0) rsp.status = ST_UNDERFLOW;
      end
      default: ;
    endcase
    rsp.count = 6'(sorted_vals.size());
    return rsp;
  endfunction

  // Driver: present queued requests, idle at random between transfers
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_rsps.push_back(predict_response(item));
      end
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item  <= pending_reqs.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done cycle is one result transfer
  always @(posedge clk) begin
    sapq_rsp_t exp_rsp;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $error("result with no request outstanding: status %0d data %0d count %0d",
               result.status, result.data, result.count);
        failed = 1'b1;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (result.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, result.status);
          failed = 1'b1;
        end
        if (result.data !== exp_rsp.data) begin
          $error("data: expected %0d, got %0d", exp_rsp.data, result.data);
          failed = 1'b1;
        end
        if (result.count !== exp_rsp.count) begin
          $error("count: expected %0d, got %0d", exp_rsp.count, result.count);
          failed = 1'b1;
        end
      end
    end
  end

  // Queue a request; track occupancy so the random stream can steer it
  task automatic add_req(logic [1:0] cmd, logic [31:0] val);
    sapq_req_t req;
    req.command = cmd;
    req.value   = val;
    pending_reqs.push_back(req);
    if (cmd == CMD_ENQ && gen_count < DEPTH) gen_count++;
    if (cmd == CMD_DEQ && gen_count > 0) gen_count--;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] val;
    case ($urandom_range(9))
      0, 1, 2, 3: val = $urandom;
      4, 5, 6:    val = 32'($urandom_range(15)) - 32'd8;  // many ties
      7: begin
        case ($urandom_range(3))
          0: val = 32'h8000_0000;
          1: val = 32'h7fff_ffff;
          2: val = 32'h0000_0000;
          default: val = 32'hffff_ffff;
        endcase
      end
      default: val = {$urandom_range(1) ? 2'b10 : 2'b01, 30'($urandom)};
    endcase
    return val;
  endfunction

  // Random stream that swings between filling and draining the queue
  task automatic add_random_stream(int n_reqs);
    stream_mode_t mode;
    int enq_pct;
    int roll;
    mode = MIXED;
    for (int i = 0; i < n_reqs; i++) begin
      if (gen_count == DEPTH && $urandom_range(3) == 0) mode = DRAIN_BIAS;
      else if (gen_count == 0 && $urandom_range(3) == 0) mode = FILL_BIAS;
      else if ($urandom_range(59) == 0) mode = stream_mode_t'($urandom_range(2));
      case (mode)
        FILL_BIAS:  enq_pct = 72;
        DRAIN_BIAS: enq_pct = 22;
        default:    enq_pct = 48;
      endcase
      roll = $urandom_range(99);
      if (roll < enq_pct) add_req(CMD_ENQ, pick_value());
      else if (roll < 91) add_req(CMD_DEQ, $urandom);
      else if (roll < 97) add_req(CMD_SIZE, $urandom);
      else add_req(CMD_UNUSED, $urandom);
    end
  endtask

  task automatic wait_all_done();
    while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty errors, unused code, extremes, ties, drain to empty
    send_idle_pct = 25;
    add_req(CMD_DEQ, 32'h0);
    add_req(CMD_SIZE, 32'hffff_ffff);
    add_req(CMD_UNUSED, 32'h1234_5678);
    add_req(CMD_ENQ, 32'h7fff_ffff);
    add_req(CMD_ENQ, 32'h8000_0000);
    add_req(CMD_ENQ, 32'h0);
    add_req(CMD_ENQ, 32'hffff_ffff);
    add_req(CMD_ENQ, 32'h1);
    add_req(CMD_ENQ, 32'h0);
    add_req(CMD_ENQ, 32'h7fff_ffff);
    add_req(CMD_SIZE, 32'h0);
    add_req(CMD_UNUSED, 32'hffff_ffff);
    repeat (7) add_req(CMD_DEQ, 32'h0);
    add_req(CMD_DEQ, 32'h0);
    add_req(CMD_SIZE, 32'h0);
    add_random_stream(400);
    wait_all_done();

    // Sender idles more; it has also paused until the queue above drained
    send_idle_pct = 59;
    add_random_stream(400);
    wait_all_done();

    // Back to back
    send_idle_pct = 0;
    add_random_stream(430);
    wait_all_done();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
